// File: hw/rtl/pwrf_pkg.sv
`default_nettype none
package pwrf_pkg;

    localparam int unsigned PAYLOAD_BYTES = 9;
    localparam logic [7:0]  FILL_BYTE     = 8'hFF;

    localparam int unsigned STEP_W  = 5;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned PROD_W  = 50;
    localparam int unsigned ACC_W   = 84;
    localparam int unsigned FRAC_LSB = 40;
    localparam int unsigned SAT_LSB  = 56;

    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SYNC  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MSG   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHAN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAGE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CONST = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIN   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SQR   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CUBE  = 3'd7;

    localparam logic [1:0] SEQ_NEXT     = 2'd0;
    localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
    localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;

    localparam logic [2:0] A_ZERO = 3'd0;
    localparam logic [2:0] A_S    = 3'd1;
    localparam logic [2:0] A_SQ   = 3'd2;
    localparam logic [2:0] A_C0   = 3'd3;
    localparam logic [2:0] A_C1   = 3'd4;
    localparam logic [2:0] A_C2   = 3'd5;
    localparam logic [2:0] A_C3   = 3'd6;

    localparam logic [2:0] B_ONE = 3'd0;
    localparam logic [2:0] B_S   = 3'd1;
    localparam logic [2:0] B_SQ0 = 3'd2;
    localparam logic [2:0] B_SQ1 = 3'd3;
    localparam logic [2:0] B_CU0 = 3'd4;
    localparam logic [2:0] B_CU1 = 3'd5;
    localparam logic [2:0] B_CU2 = 3'd6;

    localparam logic [1:0] DST_NONE = 2'd0;
    localparam logic [1:0] DST_SQ   = 2'd1;
    localparam logic [1:0] DST_CU   = 2'd2;
    localparam logic [1:0] DST_ACC  = 2'd3;

    localparam logic [3:0] BYTE_SYNC  = 4'd0;
    localparam logic [3:0] BYTE_LEN   = 4'd1;
    localparam logic [3:0] BYTE_MSG   = 4'd2;
    localparam logic [3:0] BYTE_CHAN  = 4'd3;
    localparam logic [3:0] BYTE_PAGE  = 4'd4;
    localparam logic [3:0] BYTE_EVT   = 4'd5;
    localparam logic [3:0] BYTE_FILL  = 4'd6;
    localparam logic [3:0] BYTE_ACC_L = 4'd7;
    localparam logic [3:0] BYTE_ACC_H = 4'd8;
    localparam logic [3:0] BYTE_PWR_L = 4'd9;
    localparam logic [3:0] BYTE_PWR_H = 4'd10;
    localparam logic [3:0] BYTE_CHK   = 4'd11;

    typedef struct packed {
        logic [1:0]         seq;
        logic               jump;
        logic [STEP_W-1:0]  target;
        logic [2:0]         a_sel;
        logic [2:0]         b_sel;
        logic [1:0]         dst;
        logic [SHIFT_W-1:0] shift;
        logic               fin;
        logic [3:0]         byte_sel;
    } t_uop;

    typedef struct packed {
        logic [7:0]  sync;
        logic [7:0]  msg;
        logic [7:0]  chan;
        logic [7:0]  page;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
    } t_cfg;

    function automatic t_uop mk_mul(input logic [2:0] a, input logic [2:0] b,
                                    input logic [1:0] dst, input int unsigned sh);
        t_uop u;
        u = '0;
        u.seq   = SEQ_NEXT;
        u.a_sel = a;
        u.b_sel = b;
        u.dst   = dst;
        u.shift = SHIFT_W'(sh);
        return u;
    endfunction

    function automatic t_uop mk_emit(input logic [3:0] bsel, input logic jmp);
        t_uop u;
        u = '0;
        u.seq      = SEQ_WAIT_OUT;
        u.byte_sel = bsel;
        u.jump     = jmp;
        return u;
    endfunction

    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        unique case (step)
            5'd0: begin
                u.seq = SEQ_WAIT_IN;
            end
            5'd1:  u = mk_mul(A_S,  B_S,   DST_SQ,  0);
            5'd2:  u = mk_mul(A_SQ, B_S,   DST_CU,  0);
            5'd3:  u = mk_mul(A_C0, B_ONE, DST_ACC, 24);
            5'd4:  u = mk_mul(A_C1, B_S,   DST_ACC, 16);
            5'd5:  u = mk_mul(A_C2, B_SQ0, DST_ACC, 8);
            5'd6:  u = mk_mul(A_C2, B_SQ1, DST_ACC, 24);
            5'd7:  u = mk_mul(A_C3, B_CU0, DST_ACC, 0);
            5'd8:  u = mk_mul(A_C3, B_CU1, DST_ACC, 16);
            5'd9:  u = mk_mul(A_C3, B_CU2, DST_ACC, 32);
            5'd10: u = mk_mul(A_ZERO, B_ONE, DST_NONE, 0);
            5'd11: begin
                u.seq = SEQ_NEXT;
                u.fin = 1'b1;
            end
            5'd12: u = mk_emit(BYTE_SYNC,  1'b0);
            5'd13: u = mk_emit(BYTE_LEN,   1'b0);
            5'd14: u = mk_emit(BYTE_MSG,   1'b0);
            5'd15: u = mk_emit(BYTE_CHAN,  1'b0);
            5'd16: u = mk_emit(BYTE_PAGE,  1'b0);
            5'd17: u = mk_emit(BYTE_EVT,   1'b0);
            5'd18: u = mk_emit(BYTE_FILL,  1'b0);
            5'd19: u = mk_emit(BYTE_FILL,  1'b0);
            5'd20: u = mk_emit(BYTE_ACC_L, 1'b0);
            5'd21: u = mk_emit(BYTE_ACC_H, 1'b0);
            5'd22: u = mk_emit(BYTE_PWR_L, 1'b0);
            5'd23: u = mk_emit(BYTE_PWR_H, 1'b0);
            5'd24: u = mk_emit(BYTE_CHK,   1'b1);
            default: begin
                u.seq  = SEQ_NEXT;
                u.jump = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/power_page_broadcast_framer.sv
// Power page broadcast framer.
// A speed sample (unsigned Q8.8 km/h) enters on the s_axis channel, one
// transaction per broadcast tick. The block evaluates the power curve held in
// the APB coefficient registers, saturates it to 0..65535 W, bumps the event
// count and the accumulated power, and sends a 13-byte frame on m_axis, sync
// byte first, with tlast on the closing XOR checksum byte.
// A microcoded step sequencer drives one shared 33x17 multiplier: two steps
// form s^2 and s^3, seven steps multiply coefficient by speed-power slices
// into an 84-bit accumulator, one step drains the last product and one step
// saturates and updates the counters. The frame bytes are offered after
// those steps, and s_axis_tready rises again in the cycle after the checksum
// byte is taken, so a new speed sample is accepted only once the previous
// frame has been sent.
// While the receiver holds m_axis_tready low the current byte and tlast are
// held and the sequencer waits on that step. Reset clears the sequencer,
// event count and accumulated power, and loads the register defaults. The
// user must write configuration only when no frame is in flight; unchecked.
`default_nettype none
module power_page_broadcast_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] speed_kph
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] frame_byte
    output logic             m_axis_tlast    // last_byte
);
    import pwrf_pkg::*;

    t_cfg                 r_cfg;
    t_uop                 uop;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic                 in_fire;
    logic                 out_fire;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync <= 8'd164;
            r_cfg.msg  <= 8'd78;
            r_cfg.chan <= 8'd1;
            r_cfg.page <= 8'd16;
            r_cfg.c0   <= 32'd0;
            r_cfg.c1   <= 32'd0;
            r_cfg.c2   <= 32'd0;
            r_cfg.c3   <= 32'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_SYNC:  r_cfg.sync <= pwdata[7:0];
                REG_MSG:   r_cfg.msg  <= pwdata[7:0];
                REG_CHAN:  r_cfg.chan <= pwdata[7:0];
                REG_PAGE:  r_cfg.page <= pwdata[7:0];
                REG_CONST: r_cfg.c0   <= pwdata;
                REG_LIN:   r_cfg.c1   <= pwdata;
                REG_SQR:   r_cfg.c2   <= pwdata;
                REG_CUBE:  r_cfg.c3   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SYNC:  prdata = {24'd0, r_cfg.sync};
            REG_MSG:   prdata = {24'd0, r_cfg.msg};
            REG_CHAN:  prdata = {24'd0, r_cfg.chan};
            REG_PAGE:  prdata = {24'd0, r_cfg.page};
            REG_CONST: prdata = r_cfg.c0;
            REG_LIN:   prdata = r_cfg.c1;
            REG_SQR:   prdata = r_cfg.c2;
            REG_CUBE:  prdata = r_cfg.c3;
            default:   prdata = 32'd0;
        endcase
    end

    pwrf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_uop       (uop)
    );

    assign s_axis_tready = (uop.seq == SEQ_WAIT_IN);
    assign m_axis_tvalid = (uop.seq == SEQ_WAIT_OUT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    pwrf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (uop),
        .i_cfg      (r_cfg),
        .i_in_fire  (in_fire),
        .i_speed    (s_axis_tdata),
        .i_out_fire (out_fire),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: hw/rtl/pwrf_seq.sv
`default_nettype none
module pwrf_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    output pwrf_pkg::t_uop     o_uop
);
    import pwrf_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              advance;

    assign uop   = ucode(r_step);
    assign o_uop = uop;

    always_comb begin
        unique case (uop.seq)
            SEQ_WAIT_IN:  advance = i_in_valid;
            SEQ_WAIT_OUT: advance = i_out_ready;
            default:      advance = 1'b1;
        endcase
        n_step = r_step;
        if (advance) begin
            n_step = uop.jump ? uop.target : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pwrf_dp.sv
`default_nettype none
module pwrf_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pwrf_pkg::t_uop i_uop,
    input  wire pwrf_pkg::t_cfg i_cfg,
    input  wire logic           i_in_fire,
    input  wire logic [15:0]    i_speed,
    input  wire logic           i_out_fire,
    output logic [7:0]          o_byte,
    output logic                o_last
);
    import pwrf_pkg::*;

    logic [15:0]              r_s;
    logic [31:0]              r_sq;
    logic [47:0]              r_cu;
    logic signed [PROD_W-1:0] r_prod;
    logic [SHIFT_W-1:0]       r_shift;
    logic                     r_add;
    logic signed [ACC_W-1:0]  r_acc;
    logic [15:0]              r_pwr;
    logic [7:0]               r_evt;
    logic [15:0]              r_accp;
    logic [7:0]               r_chk;

    logic signed [32:0]       a_val;
    logic [15:0]              b_val;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [15:0]              pwr;
    logic [7:0]               byte_val;

    always_comb begin
        unique case (i_uop.a_sel)
            A_S:     a_val = {17'd0, r_s};
            A_SQ:    a_val = {1'b0, r_sq};
            A_C0:    a_val = {i_cfg.c0[31], i_cfg.c0};
            A_C1:    a_val = {i_cfg.c1[31], i_cfg.c1};
            A_C2:    a_val = {i_cfg.c2[31], i_cfg.c2};
            A_C3:    a_val = {i_cfg.c3[31], i_cfg.c3};
            default: a_val = '0;
        endcase
        unique case (i_uop.b_sel)
            B_S:     b_val = r_s;
            B_SQ0:   b_val = r_sq[15:0];
            B_SQ1:   b_val = r_sq[31:16];
            B_CU0:   b_val = r_cu[15:0];
            B_CU1:   b_val = r_cu[31:16];
            B_CU2:   b_val = r_cu[47:32];
            default: b_val = 16'd1;
        endcase
    end

    assign mul_p    = a_val * $signed({1'b0, b_val});
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        priority if (r_acc[ACC_W-1]) begin
            pwr = 16'd0;
        end else if (|r_acc[ACC_W-2:SAT_LSB]) begin
            pwr = 16'hFFFF;
        end else begin
            pwr = r_acc[SAT_LSB-1:FRAC_LSB];
        end
    end

    always_comb begin
        unique case (i_uop.byte_sel)
            BYTE_SYNC:  byte_val = i_cfg.sync;
            BYTE_LEN:   byte_val = 8'(PAYLOAD_BYTES);
            BYTE_MSG:   byte_val = i_cfg.msg;
            BYTE_CHAN:  byte_val = i_cfg.chan;
            BYTE_PAGE:  byte_val = i_cfg.page;
            BYTE_EVT:   byte_val = r_evt;
            BYTE_FILL:  byte_val = FILL_BYTE;
            BYTE_ACC_L: byte_val = r_accp[7:0];
            BYTE_ACC_H: byte_val = r_accp[15:8];
            BYTE_PWR_L: byte_val = r_pwr[7:0];
            BYTE_PWR_H: byte_val = r_pwr[15:8];
            BYTE_CHK:   byte_val = r_chk;
            default:    byte_val = 8'd0;
        endcase
    end

    assign o_byte = byte_val;
    assign o_last = (i_uop.byte_sel == BYTE_CHK);

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_s <= i_speed;
        end
        unique case (i_uop.dst)
            DST_SQ:  r_sq <= mul_p[31:0];
            DST_CU:  r_cu <= mul_p[47:0];
            DST_ACC: begin
                r_prod  <= mul_p;
                r_shift <= i_uop.shift;
            end
            default: begin
            end
        endcase
        if (i_in_fire) begin
            r_acc <= '0;
        end else if (r_add) begin
            r_acc <= r_acc + (prod_ext <<< r_shift);
        end
        if (i_uop.fin) begin
            r_pwr <= pwr;
            r_chk <= 8'd0;
        end else if (i_out_fire) begin
            r_chk <= r_chk ^ byte_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add  <= 1'b0;
            r_evt  <= 8'd0;
            r_accp <= 16'd0;
        end else begin
            r_add <= (i_uop.dst == DST_ACC);
            if (i_uop.fin) begin
                r_evt  <= r_evt + 8'd1;
                r_accp <= r_accp + pwr;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pwrf_checker.sv
`default_nettype none
module pwrf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Output changed while stalled.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Input taken while a frame is being sent.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("Block not busy after an input transaction.");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("Output still valid after the checksum byte.");

endmodule

bind power_page_broadcast_framer pwrf_checker u_pwrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/power_page_broadcast_framer_tb.sv
`default_nettype none
module power_page_broadcast_framer_tb;
    import pwrf_pkg::*;

    localparam int unsigned FRAME_LEN    = PAYLOAD_BYTES + 4;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned REPORT_LIMIT = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_cfg        page_setup;
    logic [7:0]  tick_count;
    logic [15:0] power_total;
    t_frame_beat beats_due[$];
    int unsigned tx_idle_pct = 32;
    int unsigned rx_idle_pct = 47;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    power_page_broadcast_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // The exact curve sum is scaled by 2^40; bits above 55 mean saturation.
    function automatic logic [15:0] curve_watts(input logic [15:0] spd);
        logic signed [127:0] s;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic signed [127:0] sum;
        s = {112'd0, spd};
        a = $signed(page_setup.c0);
        b = $signed(page_setup.c1);
        c = $signed(page_setup.c2);
        d = $signed(page_setup.c3);
        sum = a * (128'sd1 <<< 24) + b * (s <<< 16) + c * ((s * s) <<< 8) + d * (s * s * s);
        if (sum < 0)
            return 16'd0;
        else if (sum >= (128'sd1 <<< 56))
            return 16'hFFFF;
        else
            return sum[55:40];
    endfunction

    task automatic queue_power_frame(input logic [15:0] spd);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] watts;
        logic [7:0]  chk;
        t_frame_beat beat;
        watts = curve_watts(spd);
        tick_count = tick_count + 8'd1;
        power_total = power_total + watts;
        fb[0]  = page_setup.sync;
        fb[1]  = 8'(PAYLOAD_BYTES);
        fb[2]  = page_setup.msg;
        fb[3]  = page_setup.chan;
        fb[4]  = page_setup.page;
        fb[5]  = tick_count;
        fb[6]  = FILL_BYTE;
        fb[7]  = FILL_BYTE;
        fb[8]  = power_total[7:0];
        fb[9]  = power_total[15:8];
        fb[10] = watts[7:0];
        fb[11] = watts[15:8];
        chk = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            chk = chk ^ fb[i];
        fb[FRAME_LEN-1] = chk;
        for (int i = 0; i < FRAME_LEN; i++) begin
            beat.data = fb[i];
            beat.last = (i == FRAME_LEN - 1);
            beats_due.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (beats_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected frame byte: expected none actual %02h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = beats_due.pop_front();
                if (m_axis_tdata !== want.data) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: frame_byte mismatch: expected %02h actual %02h",
                                 $time, want.data, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: last_byte mismatch: expected %b actual %b",
                                 $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    task automatic settle_frames();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (beats_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        settle_frames();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SYNC:  page_setup.sync = val[7:0];
            REG_MSG:   page_setup.msg  = val[7:0];
            REG_CHAN:  page_setup.chan = val[7:0];
            REG_PAGE:  page_setup.page = val[7:0];
            REG_CONST: page_setup.c0   = val;
            REG_LIN:   page_setup.c1   = val;
            REG_SQR:   page_setup.c2   = val;
            REG_CUBE:  page_setup.c3   = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_curve(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        apb_write(REG_CONST, a);
        apb_write(REG_LIN, b);
        apb_write(REG_SQR, c);
        apb_write(REG_CUBE, d);
    endtask

    task automatic set_header(input logic [7:0] sync, input logic [7:0] msg,
                              input logic [7:0] chan, input logic [7:0] page);
        apb_write(REG_SYNC, {24'd0, sync});
        apb_write(REG_MSG, {24'd0, msg});
        apb_write(REG_CHAN, {24'd0, chan});
        apb_write(REG_PAGE, {24'd0, page});
    endtask

    task automatic send_speed(input logic [15:0] spd);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = spd;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_power_frame(spd);
    endtask

    function automatic logic [31:0] pick_coef();
        logic [31:0] mag;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd0;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
                mag = $urandom_range(0, 32'h0040_0000) >> $urandom_range(0, 16);
                return ($urandom_range(0, 3) == 0) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 19))
            0, 1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            2, 3, 4:    return 16'($urandom_range(0, 16'h0FFF));
            5, 6, 7:    return 16'($urandom_range(0, 16'h3C00));
            default:    return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic test_default_frames();
        send_speed(16'h0000);
        send_speed(16'hFFFF);
        send_speed(16'h1234);
    endtask

    task automatic test_header_registers();
        set_header(8'h00, 8'h00, 8'h00, 8'h00);
        send_speed(16'h0100);
        set_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_speed(16'h0200);
        set_header(8'd164, 8'd78, 8'd1, 8'd16);
    endtask

    task automatic test_power_curve_corners();
        set_curve(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_speed(16'h0000);
        set_curve(32'h8000_0000, 32'd0, 32'd0, 32'd0);
        send_speed(16'h1000);
        set_curve(32'h0001_8000, 32'd0, 32'd0, 32'd0);
        send_speed(16'h0000);
        set_curve(32'd0, 32'h4000_0000, 32'd0, 32'd0);
        send_speed(16'h0400);
        send_speed(16'h03FF);
        set_curve(32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_speed(16'hFFFF);
        set_curve(32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_speed(16'hFFFF);
        set_curve(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_speed(16'hFFFF);
        set_curve(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_speed(16'hFFFF);
        set_curve(32'h000A_0000, 32'h0002_8000, 32'h0000_199A, 32'h0000_028F);
        send_speed(16'h1E00);
        send_speed(16'h0080);
        send_speed(16'hFFFF);
        set_curve(32'hFFFB_0000, 32'h0001_0000, 32'd0, 32'd0);
        send_speed(16'h0480);
        send_speed(16'h0580);
        send_speed(16'h0600);
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned count);
        settle_frames();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        set_curve(pick_coef(), pick_coef(), pick_coef(), pick_coef());
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                set_curve(pick_coef(), pick_coef(), pick_coef(), pick_coef());
            send_speed(pick_speed());
        end
    endtask

    initial begin
        page_setup = '{sync: 8'd164, msg: 8'd78, chan: 8'd1, page: 8'd16,
                       c0: 32'd0, c1: 32'd0, c2: 32'd0, c3: 32'd0};
        tick_count = 8'd0;
        power_total = 16'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_frames();
        test_header_registers();
        test_power_curve_corners();
        test_random_traffic(32, 47, 170);
        test_random_traffic(47, 32, 170);
        test_random_traffic(0, 0, 170);

        settle_frames();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && beats_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
